FILE: src/qla_pkg.sv
// Shared constants, types and helpers of the quadrant luma accumulator.
`timescale 1ns / 1ps
package qla_pkg;

  localparam int MAX_DIM  = 4096;
  localparam int SUM_BITS = 40;

  localparam int DIM_W   = 13;
  localparam int POS_W   = 12;
  localparam int PIX_W   = 8;
  localparam int INT_W   = 15;
  localparam int MEAN_W  = 16;
  localparam int AREA_W  = 25;
  localparam int ACC_W   = 32;
  localparam int MUL_A_W = 17;
  localparam int MUL_B_W = 16;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int DIV_W   = SUM_BITS + 1;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] DIM_MIN       = DIM_W'(2);
  localparam logic [DIM_W-1:0] DIM_MAX       = DIM_W'(MAX_DIM);
  localparam logic [DIM_W-1:0] WIDTH_RESET   = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET  = DIM_W'(480);

  localparam logic [MUL_B_W-1:0] W_RED   = MUL_B_W'(13933);
  localparam logic [MUL_B_W-1:0] W_GREEN = MUL_B_W'(46871);
  localparam logic [MUL_B_W-1:0] W_BLUE  = MUL_B_W'(4732);
  // ceil(2^17 / 3): exact floor(x / 3) for x below 2^17 after a 17-bit shift.
  localparam logic [MUL_B_W-1:0] RECIP3  = MUL_B_W'(43691);

  localparam logic [MEAN_W-1:0] MEAN_MAX      = '1;
  localparam logic [INT_W-1:0]  INTENSITY_MAX = INT_W'(21845);
  // Smallest weighted sum whose value divided by 768 exceeds the intensity limit.
  localparam logic [ACC_W-1:0]  ACC_SAT       = ACC_W'(21846 * 768);

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  localparam logic [2:0] OUT_WHOLE = 3'd4;

  typedef logic [SUM_BITS-1:0] sum_t;
  typedef logic [INT_W-1:0]    lum_val_t;
  typedef logic [PIX_W-1:0]    pixel_t;

  function automatic logic [MUL_B_W-1:0] weight_of(input logic [1:0] ch);
    logic [MUL_B_W-1:0] w;
    case (ch)
      CH_RED:   w = W_RED;
      CH_GREEN: w = W_GREEN;
      CH_BLUE:  w = W_BLUE;
      default:  w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v < DIM_MIN) begin
      r = DIM_MIN;
    end else if (v > DIM_MAX) begin
      r = DIM_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: src/qla_if.sv
// Pixel and result channel interfaces of the quadrant luma accumulator.
`timescale 1ns / 1ps
interface qla_pix_if;
  import qla_pkg::*;
  logic   valid;
  logic   ready;
  pixel_t red;
  pixel_t green;
  pixel_t blue;
  logic   frame_start;

  modport source (output valid, red, green, blue, frame_start, input ready);
  modport sink (input valid, red, green, blue, frame_start, output ready);
endinterface

interface qla_res_if;
  import qla_pkg::*;
  logic     valid;
  logic     ready;
  lum_val_t nw_intensity;
  lum_val_t ne_intensity;
  lum_val_t sw_intensity;
  lum_val_t se_intensity;
  lum_val_t whole_intensity;

  modport source (output valid, nw_intensity, ne_intensity, sw_intensity, se_intensity,
                  whole_intensity, input ready);
  modport sink (input valid, nw_intensity, ne_intensity, sw_intensity, se_intensity,
                whole_intensity, output ready);
endinterface

FILE: src/quadrant_luma_accumulator_core.sv
// Quadrant luma accumulator: per-quadrant RGB sums and end-of-frame intensities.
//
// Usage: RGB pixels arrive in raster order on in_ch; frame_start marks the first
// pixel of a frame and resets the position and the sums. While accumulating, a
// pixel is taken every cycle. The pixel that closes the frame starts the end-of-frame
// sequence, and in_ch.ready stays low until it is done. Five intensities (four
// quadrants and the whole frame, times 256) then appear as one request on out_ch.
// Frame size is set through cfg_we / cfg_index / cfg_data (width at index 0,
// height at index 1) and clamped to 2..4096.
// End-of-frame sequence: the frame area first, then per intensity three channel
// means (load, up to 17 restoring divide steps on the shared compare/subtract
// unit, multiply, accumulate) followed by scaling and storing, and finally the
// hand-over of the result.
// The result sits in an output register; if the receiver stalls, pixels of the next
// frame are still taken, and only the next end-of-frame hand-over waits.
// Reset restores 640 x 480, clears the position and sums, and drops out_ch.valid.
`timescale 1ns / 1ps
module quadrant_luma_accumulator_core (
  input  logic                              clk,
  input  logic                              rst_n,
  qla_pix_if.sink                           in_ch,
  qla_res_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [qla_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [qla_pkg::DIM_W-1:0]         cfg_data
);
  import qla_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_AREA  = 4'd1;
  localparam logic [3:0] S_LOAD  = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_ACC   = 4'd5;
  localparam logic [3:0] S_SCALE = 4'd6;
  localparam logic [3:0] S_STORE = 4'd7;
  localparam logic [3:0] S_PUSH  = 4'd8;

  localparam logic [4:0] STEP_TOP = 5'd16;

  logic [3:0]        state_r, state_nxt;
  logic [DIM_W-1:0]  width_r, height_r;
  logic [POS_W-1:0]  col_r, col_nxt, row_r, row_nxt;
  sum_t              sums_r [4][3];
  sum_t              sums_nxt [4][3];
  sum_t              wsum_r [3];
  sum_t              wsum_nxt [3];

  logic [AREA_W-1:0] area_r, area_nxt;
  logic [SUM_BITS-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0]  d_r, d_nxt;
  logic [4:0]        step_r, step_nxt;
  logic [MEAN_W-1:0] q_r, q_nxt;
  logic [ACC_W-1:0]  prod_r, prod_nxt, acc_r, acc_nxt;
  logic              sat_r, sat_nxt;
  logic [2:0]        o_r, o_nxt;
  logic [1:0]        ch_r, ch_nxt;
  lum_val_t          res_r [5];
  lum_val_t          res_nxt [5];

  logic              out_valid_r, out_valid_nxt;
  lum_val_t          out_nw_r, out_ne_r, out_sw_r, out_se_r, out_whole_r;
  logic              out_load;

  logic [DIM_W-1:0]  w_eff, h_eff;
  logic              pix_acc;
  logic [POS_W-1:0]  col_cur, row_cur;
  logic [1:0]        quad;
  logic              is_last, row_end;
  pixel_t            px [3];

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic [AREA_W-1:0]  count;
  sum_t               sel_sum;
  logic               ge;
  lum_val_t           res_val;

  assign w_eff = clamp_dim(width_r);
  assign h_eff = clamp_dim(height_r);

  assign in_ch.ready = (state_r == S_IDLE);
  assign pix_acc     = in_ch.valid && in_ch.ready;

  assign px[0] = in_ch.red;
  assign px[1] = in_ch.green;
  assign px[2] = in_ch.blue;

  assign col_cur = in_ch.frame_start ? '0 : col_r;
  assign row_cur = in_ch.frame_start ? '0 : row_r;
  assign quad    = {(row_cur >= h_eff[DIM_W-1:1]), (col_cur >= w_eff[DIM_W-1:1])};
  assign row_end = ({1'b0, col_cur} >= (w_eff - DIM_W'(1)));
  assign is_last = row_end && ({1'b0, row_cur} >= (h_eff - DIM_W'(1)));

  // Shared multiplier: frame area, mean times weight, and the divide-by-three step.
  always_comb begin
    case (state_r)
      S_AREA: begin
        mul_a = MUL_A_W'(w_eff);
        mul_b = MUL_B_W'(h_eff);
      end
      S_MUL: begin
        mul_a = {1'b0, q_r};
        mul_b = weight_of(ch_r);
      end
      default: begin
        mul_a = acc_r[MUL_A_W+7:8];
        mul_b = RECIP3;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign count   = (o_r == OUT_WHOLE) ? area_r : {2'b00, area_r[AREA_W-1:2]};
  assign sel_sum = (o_r == OUT_WHOLE) ? wsum_r[ch_r] : sums_r[o_r[1:0]][ch_r];
  assign ge      = ({1'b0, rem_r} >= d_r);
  assign res_val = sat_r ? INTENSITY_MAX : prod_r[ACC_W-1:17];
  assign out_load = (state_r == S_PUSH) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    sums_nxt  = sums_r;
    wsum_nxt  = wsum_r;
    area_nxt  = area_r;
    rem_nxt   = rem_r;
    d_nxt     = d_r;
    step_nxt  = step_r;
    q_nxt     = q_r;
    prod_nxt  = prod_r;
    acc_nxt   = acc_r;
    sat_nxt   = sat_r;
    o_nxt     = o_r;
    ch_nxt    = ch_r;
    res_nxt   = res_r;

    case (state_r)
      S_IDLE: begin
        if (pix_acc) begin
          for (int q = 0; q < 4; q++) begin
            for (int c = 0; c < 3; c++) begin
              sums_nxt[q][c] = (in_ch.frame_start ? '0 : sums_r[q][c]) +
                               ((quad == 2'(q)) ? SUM_BITS'(px[c]) : '0);
            end
          end
          for (int c = 0; c < 3; c++) begin
            wsum_nxt[c] = (in_ch.frame_start ? '0 : wsum_r[c]) + SUM_BITS'(px[c]);
          end
          if (is_last) begin
            col_nxt   = '0;
            row_nxt   = '0;
            o_nxt     = '0;
            ch_nxt    = CH_RED;
            acc_nxt   = '0;
            state_nxt = S_AREA;
          end else if (row_end) begin
            col_nxt = '0;
            row_nxt = row_cur + POS_W'(1);
          end else begin
            col_nxt = col_cur + POS_W'(1);
            row_nxt = row_cur;
          end
        end
      end
      S_AREA: begin
        area_nxt  = mul_p[AREA_W-1:0];
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        rem_nxt   = sel_sum;
        d_nxt     = {count, 16'b0};
        step_nxt  = STEP_TOP;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // The first compare only checks whether the mean reaches 65536.
        if (step_r == STEP_TOP) begin
          if (ge) begin
            q_nxt     = MEAN_MAX;
            state_nxt = S_MUL;
          end else begin
            d_nxt    = d_r >> 1;
            step_nxt = step_r - 5'd1;
          end
        end else begin
          if (ge) begin
            rem_nxt = rem_r - d_r[SUM_BITS-1:0];
          end
          q_nxt = {q_r[MEAN_W-2:0], ge};
          d_nxt = d_r >> 1;
          if (step_r == 5'd0) begin
            state_nxt = S_MUL;
          end else begin
            step_nxt = step_r - 5'd1;
          end
        end
      end
      S_MUL: begin
        prod_nxt  = mul_p[ACC_W-1:0];
        state_nxt = S_ACC;
      end
      S_ACC: begin
        acc_nxt = acc_r + prod_r;
        if (ch_r == CH_BLUE) begin
          state_nxt = S_SCALE;
        end else begin
          ch_nxt    = ch_r + 2'd1;
          state_nxt = S_LOAD;
        end
      end
      S_SCALE: begin
        sat_nxt   = (acc_r >= ACC_SAT);
        prod_nxt  = mul_p[ACC_W-1:0];
        state_nxt = S_STORE;
      end
      S_STORE: begin
        res_nxt[o_r] = res_val;
        if (o_r == OUT_WHOLE) begin
          for (int q = 0; q < 4; q++) begin
            for (int c = 0; c < 3; c++) begin
              sums_nxt[q][c] = '0;
            end
          end
          for (int c = 0; c < 3; c++) begin
            wsum_nxt[c] = '0;
          end
          state_nxt = S_PUSH;
        end else begin
          o_nxt     = o_r + 3'd1;
          ch_nxt    = CH_RED;
          acc_nxt   = '0;
          state_nxt = S_LOAD;
        end
      end
      S_PUSH: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      width_r     <= WIDTH_RESET;
      height_r    <= HEIGHT_RESET;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
      o_r         <= '0;
      ch_r        <= CH_RED;
      step_r      <= '0;
      for (int q = 0; q < 4; q++) begin
        for (int c = 0; c < 3; c++) begin
          sums_r[q][c] <= '0;
        end
      end
      for (int c = 0; c < 3; c++) begin
        wsum_r[c] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
      o_r         <= o_nxt;
      ch_r        <= ch_nxt;
      step_r      <= step_nxt;
      sums_r      <= sums_nxt;
      wsum_r      <= wsum_nxt;
      if (cfg_we && (cfg_index == REG_FRAME_WIDTH)) begin
        width_r <= cfg_data;
      end
      if (cfg_we && (cfg_index == REG_FRAME_HEIGHT)) begin
        height_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    area_r <= area_nxt;
    rem_r  <= rem_nxt;
    d_r    <= d_nxt;
    q_r    <= q_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    sat_r  <= sat_nxt;
    res_r  <= res_nxt;
    if (out_load) begin
      out_nw_r    <= res_r[0];
      out_ne_r    <= res_r[1];
      out_sw_r    <= res_r[2];
      out_se_r    <= res_r[3];
      out_whole_r <= res_r[4];
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.nw_intensity    = out_nw_r;
  assign out_ch.ne_intensity    = out_ne_r;
  assign out_ch.sw_intensity    = out_sw_r;
  assign out_ch.se_intensity    = out_se_r;
  assign out_ch.whole_intensity = out_whole_r;

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (step_r <= STEP_TOP))
    else $error("divide step counter out of range");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (d_r != '0))
    else $error("divisor register is zero during a divide");

  a_sums_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH) |-> ((wsum_r[0] == '0) && (wsum_r[1] == '0) && (wsum_r[2] == '0)))
    else $error("frame sums not cleared after the result");

  a_out_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> ((out_ch.whole_intensity <= INTENSITY_MAX) &&
                  (out_ch.nw_intensity <= INTENSITY_MAX)))
    else $error("intensity above its limit");

  a_obj_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) && (state_r != S_AREA) |-> (o_r <= OUT_WHOLE) && (ch_r <= CH_BLUE))
    else $error("result or channel index out of range");

endmodule
